### design/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue unit.
`default_nettype none

package bmhq_pkg;

    // Heap geometry
    localparam int HEAP_DEPTH = 256;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CHILD_W    = ADDR_W + 2;
    localparam int KEY_W      = 31;
    localparam int POS_W      = 8;

    // Operation codes
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_DELETE  = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key_in;
        logic [POS_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_out;
        logic [1:0]       status;
        logic [CNT_W-1:0] entry_count;
    } rsp_t;

    // Result handed from the heap engine to the output stage
    typedef struct packed {
        logic valid;
        rsp_t data;
    } core_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RM_CMP,
        ST_UP_CMP,
        ST_DN_CMP,
        ST_WR_FINAL,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### design/bmhq_core.sv
// Heap engine: key memory plus the sequencer for insert, extract and delete.
`default_nettype none

module bmhq_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire bmhq_pkg::req_t      req,
    output logic                     idle,
    output bmhq_pkg::core_res_t      res,
    input  wire logic                res_ack
);

    bmhq_pkg::state_t state_reg, state_next;

    logic [bmhq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [bmhq_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [bmhq_pkg::KEY_W-1:0]  key_reg, key_next;
    logic                        try_down_reg, try_down_next;
    logic [bmhq_pkg::KEY_W-1:0]  key_out_reg, key_out_next;
    logic [1:0]                  status_reg, status_next;

    // Key memory: one write port, two registered read ports
    logic [bmhq_pkg::KEY_W-1:0]  mem [bmhq_pkg::HEAP_DEPTH];
    logic                        wr_en;
    logic [bmhq_pkg::ADDR_W-1:0] wr_addr;
    logic [bmhq_pkg::KEY_W-1:0]  wr_data;
    logic [bmhq_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [bmhq_pkg::KEY_W-1:0]  rd_data_a_reg, rd_data_b_reg;

    // Index arithmetic
    logic [bmhq_pkg::ADDR_W-1:0]  parent_idx;
    logic [bmhq_pkg::ADDR_W-1:0]  grand_idx;
    logic [bmhq_pkg::CHILD_W-1:0] left_idx, right_idx;
    logic                         right_ok, sel_right;
    logic [bmhq_pkg::ADDR_W-1:0]  child_idx;
    logic [bmhq_pkg::KEY_W-1:0]   child_key;
    logic [bmhq_pkg::CHILD_W-1:0] child_left;
    logic [bmhq_pkg::CHILD_W-1:0] count_ext;
    logic [bmhq_pkg::ADDR_W-1:0]  req_pos;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bmhq_pkg::ST_IDLE;
            count_reg    <= '0;
            try_down_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            try_down_reg <= try_down_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        key_out_reg <= key_out_next;
        status_reg  <= status_next;
    end

    // Tree navigation around the current hole
    always_comb
    begin
        count_ext  = bmhq_pkg::CHILD_W'(count_reg);
        parent_idx = bmhq_pkg::ADDR_W'((idx_reg - 1'b1) >> 1);
        grand_idx  = bmhq_pkg::ADDR_W'((parent_idx - 1'b1) >> 1);
        left_idx   = (bmhq_pkg::CHILD_W'(idx_reg) << 1) + 1'b1;
        right_idx  = left_idx + 1'b1;
        right_ok   = right_idx < count_ext;
        sel_right  = right_ok && (rd_data_b_reg < rd_data_a_reg);
        child_idx  = sel_right ? bmhq_pkg::ADDR_W'(right_idx)
                               : bmhq_pkg::ADDR_W'(left_idx);
        child_key  = sel_right ? rd_data_b_reg : rd_data_a_reg;
        child_left = (bmhq_pkg::CHILD_W'(child_idx) << 1) + 1'b1;
        req_pos    = (req.mode == bmhq_pkg::MODE_EXTRACT) ? '0
                                                          : bmhq_pkg::ADDR_W'(req.position);
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        try_down_next = try_down_reg;
        key_out_next  = key_out_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = key_reg;
        rd_addr_a     = '0;
        rd_addr_b     = '0;

        unique case (state_reg)
            bmhq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_out_next = '0;
                    status_next  = bmhq_pkg::STATUS_OK;
                    unique case (req.mode)
                        bmhq_pkg::MODE_INSERT:
                        begin
                            if (count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH))
                            begin
                                status_next = bmhq_pkg::STATUS_FULL;
                                state_next  = bmhq_pkg::ST_DONE;
                            end
                            else
                            begin
                                key_next      = req.key_in;
                                idx_next      = bmhq_pkg::ADDR_W'(count_reg);
                                count_next    = count_reg + 1'b1;
                                try_down_next = 1'b0;
                                if (count_reg == '0)
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = '0;
                                    wr_data    = req.key_in;
                                    state_next = bmhq_pkg::ST_DONE;
                                end
                                else
                                begin
                                    rd_addr_a  = bmhq_pkg::ADDR_W'((count_reg - 1'b1) >> 1);
                                    state_next = bmhq_pkg::ST_UP_CMP;
                                end
                            end
                        end
                        bmhq_pkg::MODE_EXTRACT, bmhq_pkg::MODE_DELETE:
                        begin
                            if (bmhq_pkg::CHILD_W'(req_pos) >= count_ext
                                || (req.mode == bmhq_pkg::MODE_DELETE
                                    && bmhq_pkg::CHILD_W'(req.position) >= count_ext))
                            begin
                                status_next = bmhq_pkg::STATUS_ERR;
                                state_next  = bmhq_pkg::ST_DONE;
                            end
                            else
                            begin
                                idx_next   = req_pos;
                                rd_addr_a  = req_pos;
                                rd_addr_b  = bmhq_pkg::ADDR_W'(count_reg - 1'b1);
                                count_next = count_reg - 1'b1;
                                state_next = bmhq_pkg::ST_RM_CMP;
                            end
                        end
                        default:
                        begin
                            status_next = bmhq_pkg::STATUS_ERR;
                            state_next  = bmhq_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Removed key and last key are now in the read registers
            bmhq_pkg::ST_RM_CMP:
            begin
                key_out_next = rd_data_a_reg;
                if (bmhq_pkg::CNT_W'(idx_reg) == count_reg)
                begin
                    state_next = bmhq_pkg::ST_DONE;
                end
                else
                begin
                    key_next = rd_data_b_reg;
                    if (idx_reg != '0)
                    begin
                        rd_addr_a     = parent_idx;
                        try_down_next = 1'b1;
                        state_next    = bmhq_pkg::ST_UP_CMP;
                    end
                    else if (left_idx < count_ext)
                    begin
                        rd_addr_a  = bmhq_pkg::ADDR_W'(left_idx);
                        rd_addr_b  = bmhq_pkg::ADDR_W'(right_idx);
                        state_next = bmhq_pkg::ST_DN_CMP;
                    end
                    else
                    begin
                        state_next = bmhq_pkg::ST_WR_FINAL;
                    end
                end
            end

            // Parent key is in read port A
            bmhq_pkg::ST_UP_CMP:
            begin
                if (key_reg < rd_data_a_reg)
                begin
                    wr_en         = 1'b1;
                    wr_data       = rd_data_a_reg;
                    idx_next      = parent_idx;
                    try_down_next = 1'b0;
                    if (parent_idx == '0)
                    begin
                        state_next = bmhq_pkg::ST_WR_FINAL;
                    end
                    else
                    begin
                        rd_addr_a = grand_idx;
                    end
                end
                else if (try_down_reg)
                begin
                    // Moved-in key does not beat its parent: try the children
                    try_down_next = 1'b0;
                    if (left_idx < count_ext)
                    begin
                        rd_addr_a  = bmhq_pkg::ADDR_W'(left_idx);
                        rd_addr_b  = bmhq_pkg::ADDR_W'(right_idx);
                        state_next = bmhq_pkg::ST_DN_CMP;
                    end
                    else
                    begin
                        state_next = bmhq_pkg::ST_WR_FINAL;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = bmhq_pkg::ST_DONE;
                end
            end

            // Left child in port A, right child in port B
            bmhq_pkg::ST_DN_CMP:
            begin
                if (child_key < key_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = child_key;
                    idx_next = child_idx;
                    if (child_left < count_ext)
                    begin
                        rd_addr_a = bmhq_pkg::ADDR_W'(child_left);
                        rd_addr_b = bmhq_pkg::ADDR_W'(child_left + 1'b1);
                    end
                    else
                    begin
                        state_next = bmhq_pkg::ST_WR_FINAL;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = bmhq_pkg::ST_DONE;
                end
            end

            bmhq_pkg::ST_WR_FINAL:
            begin
                wr_en      = 1'b1;
                state_next = bmhq_pkg::ST_DONE;
            end

            bmhq_pkg::ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = bmhq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

    assign idle                  = (state_reg == bmhq_pkg::ST_IDLE);
    assign res.valid             = (state_reg == bmhq_pkg::ST_DONE);
    assign res.data.key_out      = key_out_reg;
    assign res.data.status       = status_reg;
    assign res.data.entry_count  = count_reg;

endmodule

`default_nettype wire

### design/binary_min_heap_queue_unit.sv
// Top level of the binary min-heap queue: heap engine plus output register.
// An error, a full heap or a first insert goes straight to result valid; other
// operations first read memory and then sift the key level by level.
// One operation at a time: the next request transfers once the engine hands its
// result on to the output register.
// Reset: asynchronous, active low; empties the heap, memory contents are kept.
`default_nettype none

module binary_min_heap_queue_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bmhq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bmhq_pkg::rsp_t     rsp
);

    logic                 core_idle;
    bmhq_pkg::core_res_t  core_res;
    logic                 res_ack;
    logic                 rsp_valid_reg, rsp_valid_next;
    bmhq_pkg::rsp_t       rsp_reg;

    bmhq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .idle      (core_idle),
        .res       (core_res),
        .res_ack   (res_ack)
    );

    // Output register loads when empty or being drained
    assign res_ack = core_res.valid && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_ack)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            rsp_reg <= core_res.data;
        end
    end

    assign req_stall = !core_idle;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("engine took a request but stayed idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entry_count <= bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH)))
        else $error("entry count above heap depth");

    a_fail_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != bmhq_pkg::STATUS_OK) |-> (rsp.key_out == '0))
        else $error("failed operation returned a key");

    a_ack_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_ack |-> (core_res.valid && !(rsp_valid_reg && rsp_stall)))
        else $error("result loaded over a stalled output");

endmodule

`default_nettype wire
